@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the stream clock and reset.
`define ASSERT_STD(lbl, prop, msg) \
    `ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

@@ hw/rtl/rse_pkg.sv @@
// Package for the Reed-Solomon encoder: constants, cell control struct, GF(2^8) helpers.
// Depends on nothing; used by the cell, control and top modules of the encoder.
`default_nettype none
package rse_pkg;

    localparam int MAX_PARITY_DEF   = 32;
    localparam int POLY_ORDER_RESET = 8;
    localparam int SYM_W            = 8;
    localparam int ORDER_W          = 5;
    localparam logic [SYM_W-1:0] FIELD_LOW = 8'h1D;
    localparam logic [SYM_W-1:0] FIELD_TOP = 8'h80;

    typedef logic [SYM_W-1:0] sym_t;

    typedef struct packed {
        logic clear;
        logic enc;
        logic shift;
        logic gen;
        sym_t fb;
        sym_t root;
    } cell_ctl_t;

    function automatic sym_t gf_xtime(input sym_t x);
        sym_t r;
        r = {x[SYM_W-2:0], 1'b0};
        if ((x & FIELD_TOP) != '0) begin
            r = r ^ FIELD_LOW;
        end
        return r;
    endfunction

    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        sym_t acc;
        sym_t x;
        acc = '0;
        x   = a;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rse_cell.sv @@
// One cell of the encoder chain: a remainder symbol and a generator coefficient.
// Depends on rse_pkg for the control struct and the GF(2^8) multiply.
`default_nettype none
module rse_cell
    import rse_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire sym_t      g_left,
    input  wire sym_t      rem_right,
    output sym_t           g_out,
    output sym_t           rem_out
);

    sym_t g_reg, g_next;
    sym_t rem_reg, rem_next;
    sym_t mul_a, mul_b, prod;

    always_comb begin
        mul_a = ctl.gen ? ctl.root : ctl.fb;
        mul_b = ctl.gen ? g_left : g_reg;
        prod  = gf_mul(mul_a, mul_b);
        g_next   = g_reg;
        rem_next = rem_reg;
        if (ctl.clear) begin
            g_next   = '0;
            rem_next = '0;
        end else if (ctl.gen) begin
            g_next = g_reg ^ prod;
        end else if (ctl.enc) begin
            rem_next = rem_right ^ prod;
        end else if (ctl.shift) begin
            rem_next = rem_right;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg   <= g_next;
        rem_reg <= rem_next;
    end

    assign g_out   = g_reg;
    assign rem_out = rem_reg;

endmodule
`default_nettype wire

@@ hw/rtl/rse_ctrl.sv @@
// Control of the encoder: handshakes, output register, parity burst and generator build.
// Depends on rse_pkg; drives the cell chain through one control struct.
`default_nettype none
module rse_ctrl
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SYM_W-1:0]   s_tdata,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [SYM_W-1:0]        m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast,
    input  wire logic               cfg_wr_en,
    input  wire logic [ORDER_W-1:0] cfg_wr_data,
    input  wire sym_t               rem_head,
    output cell_ctl_t               ctl
);

    localparam int NW       = $clog2(MAX_PARITY + 1);
    localparam int HALF     = MAX_PARITY / 2;
    localparam int RST_ORD  = (POLY_ORDER_RESET > HALF) ? HALF : POLY_ORDER_RESET;
    localparam logic [NW-1:0] NSYM_RST = NW'(2 * RST_ORD);

    logic [NW-1:0] nsym_reg, nsym_next;
    logic [NW-1:0] gen_cnt_reg, gen_cnt_next;
    logic [NW-1:0] burst_cnt_reg, burst_cnt_next;
    sym_t          root_reg, root_next;
    logic          m_valid_reg, m_valid_next;
    sym_t          m_data_reg, m_data_next;
    logic          m_par_reg, m_par_next;
    logic          m_last_reg, m_last_next;

    logic          out_free;
    logic          accept;
    logic          shift_step;
    logic          gen_step;
    logic [NW-1:0] nsym_cfg;
    int            ord_int;

    always_comb begin
        ord_int = int'(cfg_wr_data);
        if (ord_int < 1) begin
            ord_int = 1;
        end else if (ord_int > HALF) begin
            ord_int = HALF;
        end
        nsym_cfg = NW'(2 * ord_int);
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (gen_cnt_reg == '0) && (burst_cnt_reg == '0) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign shift_step = (burst_cnt_reg != '0) && out_free;
    assign gen_step   = gen_cnt_reg != '0;

    always_comb begin
        ctl.clear = !aresetn || cfg_wr_en;
        ctl.gen   = gen_step;
        ctl.enc   = accept;
        ctl.shift = shift_step;
        ctl.fb    = s_tdata ^ rem_head;
        ctl.root  = root_reg;
    end

    always_comb begin
        nsym_next      = nsym_reg;
        gen_cnt_next   = gen_cnt_reg;
        burst_cnt_next = burst_cnt_reg;
        root_next      = root_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_par_next     = m_par_reg;
        m_last_next    = m_last_reg;

        if (gen_step) begin
            gen_cnt_next = gen_cnt_reg - NW'(1);
            root_next    = gf_xtime(root_reg);
        end

        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = s_tdata;
            m_par_next   = 1'b0;
            m_last_next  = 1'b0;
            if (s_tlast) begin
                burst_cnt_next = nsym_reg;
            end
        end else if (shift_step) begin
            m_valid_next   = 1'b1;
            m_data_next    = rem_head;
            m_par_next     = 1'b1;
            m_last_next    = burst_cnt_reg == NW'(1);
            burst_cnt_next = burst_cnt_reg - NW'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            nsym_next      = nsym_cfg;
            gen_cnt_next   = nsym_cfg;
            burst_cnt_next = '0;
            root_next      = 8'h01;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsym_reg      <= NSYM_RST;
            gen_cnt_reg   <= NSYM_RST;
            burst_cnt_reg <= '0;
            root_reg      <= 8'h01;
            m_valid_reg   <= 1'b0;
        end else begin
            nsym_reg      <= nsym_next;
            gen_cnt_reg   <= gen_cnt_next;
            burst_cnt_reg <= burst_cnt_next;
            root_reg      <= root_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_par_reg  <= m_par_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_par_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

@@ hw/rtl/reed_solomon_systematic_encoder_top.sv @@
// A message item is held in the output register from the cycle after it is accepted.
// Throughput: one item per cycle within a message while m_tready does not stall the output;
// after an item with tlast the input stalls for the 2*order parity items (poly_order
// limited to 1 .. MAX_PARITY/2). Reset and every poly_order write clear the remainder
// and rebuild the generator in the chain, one root per cycle, with s_tready low.
// The systematic encoder over GF(2^8) with a chain of remainder and generator cells.
`default_nettype none
module reed_solomon_systematic_encoder_top
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SYM_W-1:0]   s_tdata,      // data_symbol
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [SYM_W-1:0]        m_tdata,      // code_symbol
    output logic                    m_tuser,      // is_parity
    output logic                    m_tlast,
    input  wire logic               cfg_wr_en,
    input  wire logic [ORDER_W-1:0] cfg_wr_data
);

    cell_ctl_t ctl;
    sym_t      g_w   [MAX_PARITY];
    sym_t      rem_w [MAX_PARITY+1];

    assign rem_w[MAX_PARITY] = '0;

    rse_ctrl #(
        .MAX_PARITY (MAX_PARITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rem_head    (rem_w[0]),
        .ctl         (ctl)
    );

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        sym_t g_left;
        if (j == 0) begin : g_first
            assign g_left = 8'h01;
        end else begin : g_rest
            assign g_left = g_w[j-1];
        end
        rse_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .g_left    (g_left),
            .rem_right (rem_w[j+1]),
            .g_out     (g_w[j]),
            .rem_out   (rem_w[j])
        );
    end

endmodule
`default_nettype wire

@@ hw/rtl/rse_checker.sv @@
// Port-level checker for the encoder top level, attached by the bind at the end.
// Depends on assert_macros.svh and on reed_solomon_systematic_encoder_top.
`include "assert_macros.svh"
`default_nettype none
module rse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast,
    input wire logic       cfg_wr_en
);

    `ASSERT_STD(a_last_is_parity, m_tvalid && m_tlast |-> m_tuser, "last item is not parity")
    `ASSERT_STD(a_eom_stalls, s_tvalid && s_tready && s_tlast |=> !s_tready, "no parity burst")
    `ASSERT_STD(a_cfg_rebuild, cfg_wr_en |=> !s_tready, "input open during generator build")
    `ASSERT_STD(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output item dropped")

endmodule

bind reed_solomon_systematic_encoder_top rse_checker u_rse_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en)
);
`default_nettype wire
